FILE: design/lz4_frame_deframer_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the LZ4 frame deframer RTL.
// ---------------------------------------------------------------------------
`ifndef LZ4_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define LZ4_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define LZ4FD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define LZ4FD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lz4fd_pkg.sv
// ---------------------------------------------------------------------------
// lz4fd_pkg
// Types, constants and helper functions of the LZ4 frame deframer.
// ---------------------------------------------------------------------------
package lz4fd_pkg;

  // Largest block size the deframer accepts, in bytes.
  localparam int BLOCK_LIMIT = 1048576;

  // Width of an internal block length and of the expected_len output.
  localparam int EXP_W     = $clog2(BLOCK_LIMIT + 1);
  localparam int OUT_EXP_W = 21;
  // Width of a decoded BD block size (largest code is 4 MiB).
  localparam int SZ_W      = 23;

  localparam logic [63:0] LIMIT64     = 64'(BLOCK_LIMIT);
  localparam logic [63:0] TWO_LIMIT64 = 64'(2 * BLOCK_LIMIT);

  // Frame magic, first byte on the wire first.
  localparam logic [7:0] MAGIC_B0 = 8'h04;
  localparam logic [7:0] MAGIC_B1 = 8'h22;
  localparam logic [7:0] MAGIC_B2 = 8'h4D;
  localparam logic [7:0] MAGIC_B3 = 8'h18;

  // FLG byte fields.
  localparam logic [1:0] FLG_VERSION = 2'b01;
  localparam int FLG_INDEP_BIT = 5;
  localparam int FLG_BCSUM_BIT = 4;
  localparam int FLG_CSIZE_BIT = 3;
  localparam int FLG_DICT_BIT  = 0;

  typedef enum logic [2:0] {
    KIND_HDR    = 3'd0,
    KIND_HDR_OK = 3'd1,
    KIND_LEN    = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_END    = 3'd4,
    KIND_ERR    = 3'd5
  } kind_t;

  typedef logic [3:0] err_t;
  localparam err_t ERR_NONE      = 4'd0;
  localparam err_t ERR_MAGIC     = 4'd1;
  localparam err_t ERR_VERSION   = 4'd2;
  localparam err_t ERR_DEPENDENT = 4'd3;
  localparam err_t ERR_BLK_CSUM  = 4'd4;
  localparam err_t ERR_DICT_ID   = 4'd5;
  localparam err_t ERR_NO_SIZE   = 4'd6;
  localparam err_t ERR_BD        = 4'd7;
  localparam err_t ERR_TOO_LARGE = 4'd8;
  localparam err_t ERR_NEED_MAX  = 4'd9;
  localparam err_t ERR_ENDMARK   = 4'd10;

  // One result beat.
  typedef struct packed {
    kind_t                kind;
    err_t                 err_code;
    logic [7:0]           data_byte;
    logic                 stored_block;
    logic                 last_in_block;
    logic [OUT_EXP_W-1:0] expected_len;
    logic                 frame_done;
  } lz4fd_res_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = MAGIC_B0;
      2'd1:    b = MAGIC_B1;
      2'd2:    b = MAGIC_B2;
      default: b = MAGIC_B3;
    endcase
    return b;
  endfunction

  // Block size selected by the BD size code; zero marks an invalid code.
  function automatic logic [SZ_W-1:0] bd_block_size(input logic [2:0] code);
    logic [SZ_W-1:0] sz;
    case (code)
      3'd4:    sz = SZ_W'(65536);
      3'd5:    sz = SZ_W'(262144);
      3'd6:    sz = SZ_W'(1048576);
      3'd7:    sz = SZ_W'(4194304);
      default: sz = '0;
    endcase
    return sz;
  endfunction

endpackage

FILE: design/lz4fd_core.sv
// ---------------------------------------------------------------------------
// lz4fd_core
// Frame parser state and the per-byte decision logic of the deframer.
// ---------------------------------------------------------------------------
module lz4fd_core
  import lz4fd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  output lz4fd_res_t res
);

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_FLG     = 4'd1,
    PH_BD      = 4'd2,
    PH_CSIZE   = 4'd3,
    PH_HCHK    = 4'd4,
    PH_LEN     = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_END     = 4'd7,
    PH_ERROR   = 4'd8
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [2:0]        byte_pos_r, byte_pos_nxt;
  logic [63:0]       rem_r, rem_nxt;
  logic [23:0]       len_sh_r, len_sh_nxt;
  logic [30:0]       pay_left_r, pay_left_nxt;
  logic [EXP_W-1:0]  blk_exp_r, blk_exp_nxt;
  logic              stored_r, stored_nxt;
  logic              bs_lim_r, bs_lim_nxt;
  err_t              err_r, err_nxt;

  err_t              new_err;
  logic              end_blk;
  logic [SZ_W-1:0]   bd_sz;
  logic [63:0]       csize;
  logic [31:0]       raw_len;
  logic [63:0]       rem_minus;
  logic              rem_le_lim;
  logic              rem_ge_2lim;

  // rem_r holds the content bytes still to come. During the header it is
  // the shift register that gathers the content size.
  assign rem_minus   = rem_r - LIMIT64;
  assign rem_le_lim  = (rem_r <= LIMIT64);
  assign rem_ge_2lim = (rem_r >= TWO_LIMIT64);
  assign bd_sz       = bd_block_size(in_byte[6:4]);
  assign csize       = {in_byte, rem_r[63:8]};
  assign raw_len     = {in_byte, len_sh_r};

  always_comb begin
    phase_nxt    = phase_r;
    byte_pos_nxt = byte_pos_r;
    rem_nxt      = rem_r;
    len_sh_nxt   = len_sh_r;
    pay_left_nxt = pay_left_r;
    blk_exp_nxt  = blk_exp_r;
    stored_nxt   = stored_r;
    bs_lim_nxt   = bs_lim_r;
    err_nxt      = err_r;
    new_err      = ERR_NONE;
    end_blk      = 1'b0;
    res          = '0;
    res.kind     = KIND_HDR;

    case (phase_r)
      PH_MAGIC: begin
        if (in_byte != magic_byte(byte_pos_r[1:0])) begin
          new_err = ERR_MAGIC;
        end else if (byte_pos_r[1:0] == 2'd3) begin
          byte_pos_nxt = '0;
          phase_nxt    = PH_FLG;
        end else begin
          byte_pos_nxt = byte_pos_r + 3'd1;
        end
      end
      PH_FLG: begin
        if (in_byte[7:6] != FLG_VERSION)   new_err = ERR_VERSION;
        else if (!in_byte[FLG_INDEP_BIT])  new_err = ERR_DEPENDENT;
        else if (in_byte[FLG_BCSUM_BIT])   new_err = ERR_BLK_CSUM;
        else if (in_byte[FLG_DICT_BIT])    new_err = ERR_DICT_ID;
        else if (!in_byte[FLG_CSIZE_BIT])  new_err = ERR_NO_SIZE;
        else                               phase_nxt = PH_BD;
      end
      PH_BD: begin
        if (bd_sz == '0) begin
          new_err = ERR_BD;
        end else if (bd_sz > SZ_W'(BLOCK_LIMIT)) begin
          new_err = ERR_TOO_LARGE;
        end else begin
          bs_lim_nxt   = (bd_sz == SZ_W'(BLOCK_LIMIT));
          byte_pos_nxt = '0;
          phase_nxt    = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        rem_nxt      = csize;
        byte_pos_nxt = byte_pos_r + 3'd1;
        if (byte_pos_r == 3'd7) begin
          // Content larger than one block needs the largest block size.
          if ((csize > LIMIT64) && !bs_lim_r) new_err = ERR_NEED_MAX;
          else                                 phase_nxt = PH_HCHK;
        end
      end
      PH_HCHK: begin
        res.kind = KIND_HDR_OK;
        if (rem_r == '0) begin
          res.frame_done = 1'b1;
          phase_nxt      = PH_END;
        end else begin
          blk_exp_nxt  = rem_le_lim ? EXP_W'(rem_r) : EXP_W'(BLOCK_LIMIT);
          byte_pos_nxt = '0;
          phase_nxt    = PH_LEN;
        end
      end
      PH_LEN: begin
        res.kind         = KIND_LEN;
        res.expected_len = OUT_EXP_W'(blk_exp_r);
        len_sh_nxt       = {in_byte, len_sh_r[23:8]};
        if (byte_pos_r[1:0] == 2'd3) begin
          if (raw_len == '0) begin
            new_err = ERR_ENDMARK;
          end else if (raw_len[31] && (raw_len[30:0] != 31'(blk_exp_r))) begin
            new_err = ERR_ENDMARK;
          end else begin
            stored_nxt       = raw_len[31];
            res.stored_block = raw_len[31];
            byte_pos_nxt     = '0;
            if (raw_len[30:0] == '0) begin
              res.last_in_block = 1'b1;
              end_blk           = 1'b1;
            end else begin
              pay_left_nxt = raw_len[30:0];
              phase_nxt    = PH_PAYLOAD;
            end
          end
        end else begin
          byte_pos_nxt = byte_pos_r + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        res.kind         = KIND_DATA;
        res.data_byte    = in_byte;
        res.stored_block = stored_r;
        res.expected_len = OUT_EXP_W'(blk_exp_r);
        pay_left_nxt     = pay_left_r - 31'd1;
        if (pay_left_r == 31'd1) begin
          res.last_in_block = 1'b1;
          end_blk           = 1'b1;
        end
      end
      PH_END: begin
        res.kind       = KIND_END;
        res.frame_done = 1'b1;
      end
      default: begin
        res.kind     = KIND_ERR;
        err_nxt      = (err_r == ERR_NONE) ? ERR_ENDMARK : err_r;
        res.err_code = err_nxt;
        phase_nxt    = PH_ERROR;
      end
    endcase

    // Closing a block: the frame is complete when no more than one block of
    // content was left, otherwise the next block length is set up.
    if (end_blk) begin
      if (rem_le_lim) begin
        res.frame_done = 1'b1;
        phase_nxt      = PH_END;
      end else begin
        rem_nxt      = rem_minus;
        blk_exp_nxt  = rem_ge_2lim ? EXP_W'(BLOCK_LIMIT) : EXP_W'(rem_minus);
        byte_pos_nxt = '0;
        phase_nxt    = PH_LEN;
      end
    end

    if (new_err != ERR_NONE) begin
      res          = '0;
      res.kind     = KIND_ERR;
      res.err_code = new_err;
      err_nxt      = new_err;
      phase_nxt    = PH_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC;
      byte_pos_r <= '0;
      err_r      <= ERR_NONE;
      rem_r      <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      byte_pos_r <= byte_pos_nxt;
      err_r      <= err_nxt;
      rem_r      <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      len_sh_r   <= len_sh_nxt;
      pay_left_r <= pay_left_nxt;
      blk_exp_r  <= blk_exp_nxt;
      stored_r   <= stored_nxt;
      bs_lim_r   <= bs_lim_nxt;
    end
  end

endmodule

FILE: design/lz4_frame_deframer_top.sv
// Output: a result beat is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle while the output is not stalled; the parser decides each byte combinationally.
// The output register is refilled in the cycle it is emptied, so no bubbles appear.
// Reset: synchronous, active-low rst_n; the parser returns to the magic check,
// the sticky error clears and the output register is emptied.
// ---------------------------------------------------------------------------
// lz4_frame_deframer_top
// LZ4 frame header and block-length parser with registered result beats.
// ---------------------------------------------------------------------------
`include "lz4_frame_deframer_top_assert.svh"

module lz4_frame_deframer_top
  import lz4fd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_kind,
  output logic [3:0]           out_err_code,
  output logic [7:0]           out_data_byte,
  output logic                 out_stored_block,
  output logic                 out_last_in_block,
  output logic [OUT_EXP_W-1:0] out_expected_len,
  output logic                 out_frame_done
);

  logic       out_valid_r, out_valid_nxt;
  lz4fd_res_t res_r;
  lz4fd_res_t res_comb;
  logic       step;

  // A byte is taken whenever the output register is empty or being drained.
  assign in_stall = out_valid_r && out_stall;
  assign step     = in_valid && !in_stall;

  lz4fd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_byte (in_byte),
    .res     (res_comb)
  );

  always_comb begin
    if (step) out_valid_nxt = 1'b1;
    else      out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_comb;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = res_r.kind;
  assign out_err_code      = res_r.err_code;
  assign out_data_byte     = res_r.data_byte;
  assign out_stored_block  = res_r.stored_block;
  assign out_last_in_block = res_r.last_in_block;
  assign out_expected_len  = res_r.expected_len;
  assign out_frame_done    = res_r.frame_done;

  `LZ4FD_ASSERT_NOW(a_err_code_nonzero, out_valid_r && (res_r.kind == KIND_ERR), res_r.err_code != ERR_NONE, "error beat without an error code")
  `LZ4FD_ASSERT_NOW(a_err_code_only_on_err, out_valid_r && (res_r.kind != KIND_ERR), res_r.err_code == ERR_NONE, "error code on a non-error beat")
  `LZ4FD_ASSERT_NOW(a_last_kind, out_valid_r && res_r.last_in_block, (res_r.kind == KIND_DATA) || (res_r.kind == KIND_LEN), "block end marked outside a length or payload beat")
  `LZ4FD_ASSERT_NEXT(a_err_sticky, step && out_valid_r && (res_r.kind == KIND_ERR) && !out_stall, out_valid_r && (res_r.kind == KIND_ERR) && (res_r.err_code == $past(res_r.err_code)), "error beat not repeated with the same code")

endmodule
